// ===== rtl/text_line_offset_index_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line-offset index
// Concurrent assertion wrappers shared by the front and back ends of the
// block. They compile to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_OFFSET_INDEX_ASSERT_SVH
`define TEXT_LINE_OFFSET_INDEX_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge while the block is out of reset.
`define TLOI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Same check with a message of its own.
`define TLOI_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define TLOI_ASSERT(lbl, clk, rst_n, prop)
`define TLOI_ASSERT_MSG(lbl, clk, rst_n, prop, msg)

`endif

`endif

// ===== rtl/tloi_pkg.sv =====
// ----------------------------------------------------------------------------
// Line-offset index package
// Shared constants, command and status codes, and types of the block.
// ----------------------------------------------------------------------------
package tloi_pkg;

    // Default sizes of the line-start table and of text offsets.
    localparam int MAX_LINES_DEFAULT   = 1024;
    localparam int OFFSET_BITS_DEFAULT = 20;

    // Fixed field widths.
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    // Command codes as they arrive on the input stream.
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LINE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POSITION = 3'd4;

    // Status codes of a result.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LINE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_COLUMN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd4;

    // Operation after classification in the front end.
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND_CHAR,
        OP_APPEND_NL,
        OP_LINE,
        OP_LOCATE,
        OP_POSITION,
        OP_NONE
    } t_op;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_READ_BEGIN,
        B_READ_STOP,
        B_SEARCH,
        B_DONE
    } t_back_state;

    // Head-of-queue control handed from front to back.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_req_ctl;

endpackage

// ===== rtl/tloi_front.sv =====
// ----------------------------------------------------------------------------
// Line-offset index front end
// Accepts requests, classifies each command into an operation and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
`include "text_line_offset_index_assert.svh"

module tloi_front
    import tloi_pkg::*;
#(
    parameter int MAX_LINES   = MAX_LINES_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [CMD_W-1:0]                    i_cmd,
    input  logic [BYTE_W-1:0]                   i_text_byte,
    input  logic [$clog2(MAX_LINES)-1:0]        i_line_number,
    input  logic [OFFSET_BITS-1:0]              i_column,
    input  logic [OFFSET_BITS-1:0]              i_text_offset,
    output t_req_ctl                            o_req,
    output logic [$clog2(MAX_LINES)-1:0]        o_req_line,
    output logic [OFFSET_BITS-1:0]              o_req_col,
    output logic [OFFSET_BITS-1:0]              o_req_off,
    input  logic                                i_pop
);

    localparam int LINE_BITS = $clog2(MAX_LINES);
    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    t_op                    cls_op;
    logic                   req_push;

    t_op                    r_q_op   [QUEUE_DEPTH];
    logic [LINE_BITS-1:0]   r_q_line [QUEUE_DEPTH];
    logic [OFFSET_BITS-1:0] r_q_col  [QUEUE_DEPTH];
    logic [OFFSET_BITS-1:0] r_q_off  [QUEUE_DEPTH];

    logic [QPTR_BITS-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0]    r_count,  n_count;

    // Command decode; appends are split by whether the byte ends a line.
    always_comb begin
        unique case (i_cmd)
            CMD_CLEAR:    cls_op = OP_CLEAR;
            CMD_APPEND:   cls_op = (i_text_byte == NEWLINE_BYTE) ? OP_APPEND_NL
                                                                 : OP_APPEND_CHAR;
            CMD_LINE:     cls_op = OP_LINE;
            CMD_LOCATE:   cls_op = OP_LOCATE;
            CMD_POSITION: cls_op = OP_POSITION;
            default:      cls_op = OP_NONE;
        endcase
    end

    assign o_ready  = (r_count != CNT_BITS'(QUEUE_DEPTH));
    assign req_push = i_valid && o_ready;

    // Queue pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (req_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_rd_ptr + 1'b1;
        end
        if (req_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!req_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (req_push) begin
            r_q_op[r_wr_ptr]   <= cls_op;
            r_q_line[r_wr_ptr] <= i_line_number;
            r_q_col[r_wr_ptr]  <= i_column;
            r_q_off[r_wr_ptr]  <= i_text_offset;
        end
    end

    // Head of the queue toward the back end.
    assign o_req.valid = (r_count != '0);
    assign o_req.op    = r_q_op[r_rd_ptr];
    assign o_req_line  = r_q_line[r_rd_ptr];
    assign o_req_col   = r_q_col[r_rd_ptr];
    assign o_req_off   = r_q_off[r_rd_ptr];

    `TLOI_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_BITS'(QUEUE_DEPTH))
    `TLOI_ASSERT_MSG(a_pop_nonempty, i_clk, i_rst_n, i_pop |-> (r_count != '0), "pop from empty queue")
    `TLOI_ASSERT(a_fill_step, i_clk, i_rst_n, (req_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))

endmodule

// ===== rtl/tloi_back.sv =====
// ----------------------------------------------------------------------------
// Line-offset index back end
// Holds the text length, the line count and the line-start memory, carries
// out one request at a time and registers its result toward the output.
// ----------------------------------------------------------------------------
`include "text_line_offset_index_assert.svh"

module tloi_back
    import tloi_pkg::*;
#(
    parameter int MAX_LINES   = MAX_LINES_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_req_ctl                            i_req,
    input  logic [$clog2(MAX_LINES)-1:0]        i_req_line,
    input  logic [OFFSET_BITS-1:0]              i_req_col,
    input  logic [OFFSET_BITS-1:0]              i_req_off,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [STATUS_W-1:0]                 o_status,
    output logic [$clog2(MAX_LINES)-1:0]        o_found_line,
    output logic [OFFSET_BITS-1:0]              o_found_column,
    output logic [OFFSET_BITS-1:0]              o_result_offset,
    output logic [OFFSET_BITS-1:0]              o_line_begin,
    output logic [OFFSET_BITS-1:0]              o_line_content_stop,
    output logic [OFFSET_BITS-1:0]              o_line_stop
);

    localparam int LINE_BITS = $clog2(MAX_LINES);
    localparam int LH_BITS   = $clog2(MAX_LINES + 1);

    // Sequencer and architectural state.
    t_back_state            r_state, n_state;
    logic [LH_BITS-1:0]     r_lines, n_lines;
    logic [OFFSET_BITS-1:0] r_length, n_length;

    // Working registers of the request in progress.
    t_op                    r_op, n_op;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_col, n_col;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic [OFFSET_BITS-1:0] r_stop, n_stop;
    logic                   r_last, n_last;
    logic [LINE_BITS-1:0]   r_lo, n_lo;
    logic [LINE_BITS-1:0]   r_hi, n_hi;
    logic [LINE_BITS-1:0]   r_mid, n_mid;
    logic [OFFSET_BITS-1:0] r_lo_start, n_lo_start;

    // Line-start memory with one write and one registered read port.
    logic [OFFSET_BITS-1:0] r_start_table [MAX_LINES];
    logic [OFFSET_BITS-1:0] r_rdata;
    logic                   r_rd_zero;
    logic [LINE_BITS-1:0]   rd_addr;
    logic                   mem_we;
    logic [OFFSET_BITS-1:0] rd_val;

    // Output register.
    logic                   r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [LINE_BITS-1:0]   r_out_line;
    logic [OFFSET_BITS-1:0] r_out_column;
    logic [OFFSET_BITS-1:0] r_out_result;
    logic [OFFSET_BITS-1:0] r_out_begin;
    logic [OFFSET_BITS-1:0] r_out_content;
    logic [OFFSET_BITS-1:0] r_out_stop;

    // Result handed to the output register.
    logic                   res_push;
    logic [STATUS_W-1:0]    res_status;
    logic [LINE_BITS-1:0]   res_line;
    logic [OFFSET_BITS-1:0] res_column;
    logic [OFFSET_BITS-1:0] res_result;
    logic [OFFSET_BITS-1:0] res_begin;
    logic [OFFSET_BITS-1:0] res_content;
    logic [OFFSET_BITS-1:0] res_stop;

    // Shared conditions.
    logic                   out_free;
    logic                   start_ok;
    logic                   line_ok;
    logic                   off_ok;
    logic                   text_full;
    logic                   table_full;
    logic                   single_line;
    logic                   has_next;
    logic [LINE_BITS-1:0]   next_line;
    logic [OFFSET_BITS-1:0] line_span;

    // One step of the search.
    logic                   go_up;
    logic [LINE_BITS-1:0]   s_lo;
    logic [LINE_BITS-1:0]   s_hi;
    logic [OFFSET_BITS-1:0] s_lo_start;
    logic [LH_BITS-1:0]     s_span;
    logic [LINE_BITS-1:0]   s_mid;
    logic                   s_more;

    // Entry zero always reads as offset zero, so it is never written.
    assign rd_val      = r_rd_zero ? '0 : r_rdata;

    assign out_free    = !r_out_valid || i_ready;
    assign start_ok    = (r_state == B_IDLE) && i_req.valid && out_free;
    assign line_ok     = (LH_BITS'(i_req_line) < r_lines);
    assign off_ok      = (i_req_off <= r_length);
    assign text_full   = (r_length == {OFFSET_BITS{1'b1}});
    assign table_full  = (r_lines == LH_BITS'(MAX_LINES));
    assign single_line = (r_lines == LH_BITS'(1));
    assign has_next    = ((LH_BITS'(r_line) + LH_BITS'(1)) < r_lines);
    assign next_line   = LINE_BITS'(LH_BITS'(r_line) + LH_BITS'(1));
    assign line_span   = r_stop - r_begin;

    // Keep the upper half when the probed start lies at or below the offset.
    assign go_up      = (rd_val <= r_off);
    assign s_lo       = go_up ? r_mid : r_lo;
    assign s_hi       = go_up ? r_hi : r_mid - 1'b1;
    assign s_lo_start = go_up ? rd_val : r_lo_start;
    assign s_span     = LH_BITS'(s_hi) - LH_BITS'(s_lo) + LH_BITS'(1);
    assign s_mid      = LINE_BITS'(LH_BITS'(s_lo) + (s_span >> 1));
    assign s_more     = (s_lo < s_hi);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (start_ok) begin
                    case (i_req.op)
                        OP_LINE, OP_POSITION: begin
                            if (line_ok) begin
                                n_state = B_READ_BEGIN;
                            end
                        end
                        OP_LOCATE: begin
                            if (off_ok && !single_line) begin
                                n_state = B_SEARCH;
                            end
                        end
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_READ_BEGIN: begin
                n_state = has_next ? B_READ_STOP : B_DONE;
            end
            B_READ_STOP: begin
                n_state = B_DONE;
            end
            B_SEARCH: begin
                if (!s_more) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Datapath, memory control and result of each state.
    always_comb begin
        n_lines     = r_lines;
        n_length    = r_length;
        n_op        = r_op;
        n_line      = r_line;
        n_col       = r_col;
        n_off       = r_off;
        n_begin     = r_begin;
        n_stop      = r_stop;
        n_last      = r_last;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_lo_start  = r_lo_start;
        rd_addr     = r_mid;
        mem_we      = 1'b0;
        o_pop       = 1'b0;
        res_push    = 1'b0;
        res_status  = ST_OK;
        res_line    = '0;
        res_column  = '0;
        res_result  = '0;
        res_begin   = '0;
        res_content = '0;
        res_stop    = '0;

        unique case (r_state)
            B_IDLE: begin
                if (start_ok) begin
                    o_pop = 1'b1;
                    n_op  = i_req.op;
                    n_line = i_req_line;
                    n_col  = i_req_col;
                    n_off  = i_req_off;
                    case (i_req.op)
                        OP_CLEAR: begin
                            n_lines  = LH_BITS'(1);
                            n_length = '0;
                            res_push = 1'b1;
                        end
                        OP_APPEND_CHAR: begin
                            res_push = 1'b1;
                            if (text_full) begin
                                res_status = ST_OVERFLOW;
                            end else begin
                                n_length = r_length + 1'b1;
                            end
                        end
                        OP_APPEND_NL: begin
                            res_push = 1'b1;
                            if (text_full || table_full) begin
                                res_status = ST_OVERFLOW;
                            end else begin
                                mem_we   = 1'b1;
                                n_length = r_length + 1'b1;
                                n_lines  = r_lines + 1'b1;
                            end
                        end
                        OP_LINE, OP_POSITION: begin
                            if (line_ok) begin
                                rd_addr = i_req_line;
                            end else begin
                                res_push   = 1'b1;
                                res_status = ST_BAD_LINE;
                            end
                        end
                        OP_LOCATE: begin
                            if (!off_ok) begin
                                res_push   = 1'b1;
                                res_status = ST_BAD_OFFSET;
                            end else if (single_line) begin
                                res_push   = 1'b1;
                                res_column = i_req_off;
                            end else begin
                                n_lo       = '0;
                                n_hi       = LINE_BITS'(r_lines - 1'b1);
                                n_mid      = LINE_BITS'(r_lines >> 1);
                                n_lo_start = '0;
                                rd_addr    = LINE_BITS'(r_lines >> 1);
                            end
                        end
                        default: begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            B_READ_BEGIN: begin
                n_begin = rd_val;
                if (has_next) begin
                    rd_addr = next_line;
                    n_last  = 1'b0;
                end else begin
                    n_stop = r_length;
                    n_last = 1'b1;
                end
            end
            B_READ_STOP: begin
                n_stop = rd_val;
            end
            B_SEARCH: begin
                n_lo       = s_lo;
                n_hi       = s_hi;
                n_lo_start = s_lo_start;
                n_mid      = s_mid;
                rd_addr    = s_mid;
            end
            B_DONE: begin
                if (out_free) begin
                    res_push = 1'b1;
                    case (r_op)
                        OP_LINE: begin
                            res_begin   = r_begin;
                            res_content = r_last ? r_stop : r_stop - 1'b1;
                            res_stop    = r_stop;
                        end
                        OP_POSITION: begin
                            if (r_col > line_span) begin
                                res_status = ST_BAD_COLUMN;
                            end else begin
                                res_result = r_begin + r_col;
                            end
                        end
                        OP_LOCATE: begin
                            res_line   = r_lo;
                            res_column = r_off - r_lo_start;
                        end
                        default: res_status = ST_OK;
                    endcase
                end
            end
            default: res_push = 1'b0;
        endcase
    end

    // Output slot fills on a result and empties when taken.
    always_comb begin
        if (res_push) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_lines     <= LH_BITS'(1);
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lines     <= n_lines;
            r_length    <= n_length;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_line     <= n_line;
        r_col      <= n_col;
        r_off      <= n_off;
        r_begin    <= n_begin;
        r_stop     <= n_stop;
        r_last     <= n_last;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_lo_start <= n_lo_start;
        if (res_push) begin
            r_out_status  <= res_status;
            r_out_line    <= res_line;
            r_out_column  <= res_column;
            r_out_result  <= res_result;
            r_out_begin   <= res_begin;
            r_out_content <= res_content;
            r_out_stop    <= res_stop;
        end
    end

    // A newline stores the offset just after it as the next line start.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_start_table[LINE_BITS'(r_lines)] <= r_length + 1'b1;
        end
        r_rdata   <= r_start_table[rd_addr];
        r_rd_zero <= (rd_addr == '0);
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out_status;
    assign o_found_line        = r_out_line;
    assign o_found_column      = r_out_column;
    assign o_result_offset     = r_out_result;
    assign o_line_begin        = r_out_begin;
    assign o_line_content_stop = r_out_content;
    assign o_line_stop         = r_out_stop;

    `TLOI_ASSERT(a_no_pop_busy, i_clk, i_rst_n, (r_state != B_IDLE) |-> !o_pop)
    `TLOI_ASSERT(a_lines_range, i_clk, i_rst_n, (r_lines != '0) && (r_lines <= LH_BITS'(MAX_LINES)))
    `TLOI_ASSERT_MSG(a_search_order, i_clk, i_rst_n, (r_state == B_SEARCH) |-> (r_lo < r_hi), "search bounds crossed")
    `TLOI_ASSERT(a_found_start, i_clk, i_rst_n, ((r_state == B_DONE) && (r_op == OP_LOCATE)) |-> (r_lo_start <= r_off))

endmodule

// ===== rtl/text_line_offset_index.sv =====
// ----------------------------------------------------------------------------
// Text line-offset index
// Builds a table of line starts from streamed text bytes and answers line,
// offset-to-position and position-to-offset queries against it.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                 Transfer
//  s_axis    in         tuser: cmd; tdata: byte, line, column,  tvalid & tready
//                       offset
//  m_axis    out        tuser: status; tdata: line, column,     tvalid & tready
//                       result, begin, content stop, stop
//
//  Clear, append, unknown commands and bad line or offset errors are
//  answered straight from the idle state. A line query reads the line-start
//  memory for the line's begin and, unless it is the last line, for its
//  stop; a position query does the same. An offset query does one memory
//  read per binary-search step, and is answered directly while a single
//  line is held.
//  Reset is synchronous; line zero always reads as offset zero, so no
//  clearing pass runs. A two-entry request queue and an output register let
//  either side stall without stopping the other.
// ----------------------------------------------------------------------------
module text_line_offset_index
    import tloi_pkg::*;
#(
    parameter int MAX_LINES   = MAX_LINES_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // Fields from bit 0 up: text_byte, line_number, column, text_offset.
    input  logic [((BYTE_W + $clog2(MAX_LINES) + 2 * OFFSET_BITS + 7) / 8) * 8 - 1:0]
                                    i_s_axis_tdata,
    // Fields from bit 0 up: cmd.
    input  logic [CMD_W-1:0]        i_s_axis_tuser,
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    // Fields from bit 0 up: found_line, found_column, result_offset,
    // line_begin, line_content_stop, line_stop.
    output logic [(($clog2(MAX_LINES) + 5 * OFFSET_BITS + 7) / 8) * 8 - 1:0]
                                    o_m_axis_tdata,
    // Fields from bit 0 up: status.
    output logic [STATUS_W-1:0]     o_m_axis_tuser
);

    localparam int LINE_BITS   = $clog2(MAX_LINES);
    localparam int IN_LINE_LSB = BYTE_W;
    localparam int IN_COL_LSB  = IN_LINE_LSB + LINE_BITS;
    localparam int IN_OFF_LSB  = IN_COL_LSB + OFFSET_BITS;
    localparam int OUT_W       = ((LINE_BITS + 5 * OFFSET_BITS + 7) / 8) * 8;

    t_req_ctl               req;
    logic [LINE_BITS-1:0]   req_line;
    logic [OFFSET_BITS-1:0] req_col;
    logic [OFFSET_BITS-1:0] req_off;
    logic                   req_pop;

    logic [LINE_BITS-1:0]   found_line;
    logic [OFFSET_BITS-1:0] found_column;
    logic [OFFSET_BITS-1:0] result_offset;
    logic [OFFSET_BITS-1:0] line_begin;
    logic [OFFSET_BITS-1:0] line_content_stop;
    logic [OFFSET_BITS-1:0] line_stop;

    // Request intake and classification.
    tloi_front #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_cmd         (i_s_axis_tuser),
        .i_text_byte   (i_s_axis_tdata[BYTE_W-1:0]),
        .i_line_number (i_s_axis_tdata[IN_LINE_LSB +: LINE_BITS]),
        .i_column      (i_s_axis_tdata[IN_COL_LSB +: OFFSET_BITS]),
        .i_text_offset (i_s_axis_tdata[IN_OFF_LSB +: OFFSET_BITS]),
        .o_req         (req),
        .o_req_line    (req_line),
        .o_req_col     (req_col),
        .o_req_off     (req_off),
        .i_pop         (req_pop)
    );

    // Table keeping and query execution.
    tloi_back #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req               (req),
        .i_req_line          (req_line),
        .i_req_col           (req_col),
        .i_req_off           (req_off),
        .o_pop               (req_pop),
        .o_valid             (o_m_axis_tvalid),
        .i_ready             (i_m_axis_tready),
        .o_status            (o_m_axis_tuser),
        .o_found_line        (found_line),
        .o_found_column      (found_column),
        .o_result_offset     (result_offset),
        .o_line_begin        (line_begin),
        .o_line_content_stop (line_content_stop),
        .o_line_stop         (line_stop)
    );

    // Result fields packed from the lowest bit, zero-filled to whole bytes.
    assign o_m_axis_tdata = OUT_W'({line_stop, line_content_stop, line_begin,
                                    result_offset, found_column, found_line});

endmodule
